[design/srq_pkg.sv]
package srq_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_BITS  = 32;

    // memory address and element count widths
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // fixed widths of the channel fields
    localparam int IN_VALUE_W = 32;
    localparam int RANK_W     = 11;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [VALUE_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [ADDR_W-1:0]            addr_t;

    // low VALUE_BITS bits of the input, top bit taken as sign
    function automatic key_t to_key(input logic signed [IN_VALUE_W-1:0] v);
        return key_t'(v);
    endfunction

endpackage

[design/srq_ram.sv]
module srq_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/sorted_rank_query.sv]
// channel  ports                          direction  beat
// s_       s_valid s_ready s_mode s_value  in         one load or query
// m_       m_valid m_ready m_rank_count    out        one result per query
//          m_overflow
//
// a query runs a binary search over the sorted table, one probe per cycle.
// a load runs the same search, then shifts the tail up one entry per cycle through
// the single write port and writes the new entry into the gap it leaves.
// a load into a full table is not stored and sets the overflow flag.
// reset clears state, count, and pend, overflow and valid flags; the table needs no clearing.
// a result waits in the output register; a new item is taken while it waits.
module sorted_rank_query
    import srq_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic signed [IN_VALUE_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [RANK_W-1:0]            m_rank_count,
    output logic                         m_overflow
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_SEARCH,
        ST_RESULT,
        ST_SHIFT,
        ST_INSERT
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   ovf_reg, ovf_next;
    logic   mode_reg, mode_next;
    key_t   key_reg, key_next;
    cnt_t   lo_reg, lo_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   mid_reg, mid_next;
    cnt_t   src_reg, src_next;
    logic   pend_reg, pend_next;
    cnt_t   pend_addr_reg, pend_addr_next;
    logic   m_valid_reg, m_valid_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic   m_ovf_reg, m_ovf_next;

    logic              wr_en;
    addr_t             wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic              rd_en;
    addr_t             rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    key_t  rd_key;
    logic  rd_le;
    cnt_t  srch_lo, srch_hi, srch_mid, probe_mid, pend_dst;

    srq_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_BITS),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_rank_count = rank_reg;
    assign m_overflow   = m_ovf_reg;

    assign rd_key    = $signed(rd_data);
    assign rd_le     = (rd_key <= key_reg);
    // narrow the window with the entry that just came back
    assign srch_lo   = rd_le ? cnt_t'(mid_reg + cnt_t'(1)) : lo_reg;
    assign srch_hi   = rd_le ? hi_reg : mid_reg;
    assign srch_mid  = srch_lo + ((srch_hi - srch_lo) >> 1);
    assign probe_mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pend_dst  = cnt_t'(pend_addr_reg + cnt_t'(1));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        src_next       = src_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        m_valid_next   = m_valid_reg;
        rank_next      = rank_reg;
        m_ovf_next     = m_ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = key_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next = s_mode;
                    key_next  = to_key(s_value);
                    lo_next   = '0;
                    hi_next   = count_reg;
                    if (s_mode == MODE_LOAD && count_reg == cnt_t'(TABLE_DEPTH)) begin
                        ovf_next = 1'b1;
                    end else begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (lo_reg < hi_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = probe_mid[ADDR_W-1:0];
                    mid_next   = probe_mid;
                    state_next = ST_SEARCH;
                end else begin
                    src_next   = count_reg;
                    pend_next  = 1'b0;
                    state_next = (mode_reg == MODE_QUERY) ? ST_RESULT : ST_SHIFT;
                end
            end
            ST_SEARCH: begin
                lo_next = srch_lo;
                hi_next = srch_hi;
                if (srch_lo < srch_hi) begin
                    rd_en    = 1'b1;
                    rd_addr  = srch_mid[ADDR_W-1:0];
                    mid_next = srch_mid;
                end else begin
                    src_next   = count_reg;
                    pend_next  = 1'b0;
                    state_next = (mode_reg == MODE_QUERY) ? ST_RESULT : ST_SHIFT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    rank_next    = RANK_W'(lo_reg);
                    m_ovf_next   = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                // entry read last cycle moves up one slot
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_dst[ADDR_W-1:0];
                    wr_data = rd_data;
                end
                if (src_reg > lo_reg) begin
                    rd_en          = 1'b1;
                    rd_addr        = ADDR_W'(src_reg - cnt_t'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_t'(src_reg - cnt_t'(1));
                    src_next       = cnt_t'(src_reg - cnt_t'(1));
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[ADDR_W-1:0];
                wr_data    = key_reg;
                count_next = cnt_t'(count_reg + cnt_t'(1));
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        src_reg       <= src_next;
        pend_addr_reg <= pend_addr_next;
        rank_reg      <= rank_next;
        m_ovf_reg     <= m_ovf_next;
    end

endmodule
